// ----- rtl/core/rcsfe_pkg.sv -----
// shared types and constants for the rc stick frame encoder
`timescale 1ns / 1ps

package rcsfe_pkg;

    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [1:0] CFG_PITCH_OFFSET = 2'd0;
    localparam logic [1:0] CFG_ROLL_OFFSET  = 2'd1;
    localparam logic [1:0] CFG_SCALE        = 2'd2;

    localparam logic [9:0] SCALE_RESET = 10'd1003;

    // trim button codes
    localparam logic [2:0] BTN_ROLL_UP    = 3'd1;
    localparam logic [2:0] BTN_ROLL_DOWN  = 3'd2;
    localparam logic [2:0] BTN_PITCH_UP   = 3'd3;
    localparam logic [2:0] BTN_PITCH_DOWN = 3'd4;

    localparam int MAP_BASE      = 1100;
    localparam int THR_BASE      = 1000;
    localparam int YAW_MIN       = 1190;
    localparam int YAW_MAX       = 1810;
    localparam int THR_ACTIVE    = 1200;
    localparam int BAT_GAIN      = 496;
    localparam int BAT_LOW_LEVEL = 310;
    localparam int TRIM_STEP     = 500;
    localparam int TRIM_LIMIT    = 2500;

    // frame header bytes
    localparam logic [7:0] SYNC_0   = 8'hAA;
    localparam logic [7:0] SYNC_1   = 8'hAF;
    localparam logic [7:0] CH_ID    = 8'h03;
    localparam logic [7:0] CH_LEN   = 8'h10;
    localparam logic [7:0] TRIM_ID  = 8'h16;
    localparam logic [7:0] TRIM_LEN = 8'h04;

    // byte positions in the serialized output of one item
    localparam logic [4:0] POS_CH_WORDS   = 5'd4;
    localparam logic [4:0] POS_CH_SUM     = 5'd20;
    localparam logic [4:0] POS_TRIM_START = 5'd21;
    localparam logic [4:0] POS_TRIM_WORDS = 5'd25;
    localparam logic [4:0] POS_TRIM_SUM   = 5'd29;

    // one classified item handed from front to back
    typedef struct packed {
        logic [10:0]       thr;
        logic [11:0]       yaw;
        logic [11:0]       roll;
        logic [11:0]       pitch;
        logic [3:0][15:0]  aux;
        logic              bat_low;
        logic              thr_active;
        logic              trim_en;
        logic [15:0]       roll_trim;
        logic [15:0]       pitch_trim;
    } t_job;

endpackage

// ----- rtl/core/rcsfe_front.sv -----
// front end: config registers, channel mapping, trim state and job build
`timescale 1ns / 1ps

module rcsfe_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [9:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [111:0]       i_data,
    output logic               o_push,
    input  logic               i_push_ready,
    output rcsfe_pkg::t_job    o_job
);

    localparam logic signed [12:0] TRIM_STEP_S = 13'(rcsfe_pkg::TRIM_STEP);
    localparam logic signed [12:0] TRIM_LIM_S  = 13'(rcsfe_pkg::TRIM_LIMIT);

    logic [7:0]         r_pitch_off;
    logic [7:0]         r_roll_off;
    logic [9:0]         r_scale;
    logic signed [12:0] r_roll_trim;
    logic signed [12:0] r_pitch_trim;
    logic               r_pend;

    logic signed [12:0] n_roll_trim;
    logic signed [12:0] n_pitch_trim;
    logic               press;

    logic [7:0]  thr_s, yaw_s, roll_s, pitch_s, bat_s;
    logic [2:0]  btn;
    logic signed [9:0] roll_diff, pitch_diff;
    logic [7:0]  roll_c, pitch_c;
    logic [17:0] roll_prod, pitch_prod, yaw_prod;
    logic [11:0] roll_map, pitch_map, yaw_map, yaw_clamp;
    logic [10:0] thr_map;
    logic [16:0] bat_prod;
    logic        accept;

    assign thr_s   = i_data[7:0];
    assign yaw_s   = i_data[15:8];
    assign roll_s  = i_data[23:16];
    assign pitch_s = i_data[31:24];
    assign bat_s   = i_data[39:32];
    assign btn     = i_data[106:104];

    assign o_ready = i_push_ready;
    assign o_push  = i_valid;
    assign accept  = i_valid && i_push_ready;

    always_comb begin
        roll_diff  = $signed({2'b00, roll_s}) - $signed({{2{r_roll_off[7]}}, r_roll_off});
        pitch_diff = $signed({2'b00, pitch_s}) - $signed({{2{r_pitch_off[7]}}, r_pitch_off});
        if (roll_diff[9]) begin
            roll_c = 8'd0;
        end else if (roll_diff[8]) begin
            roll_c = 8'hFF;
        end else begin
            roll_c = roll_diff[7:0];
        end
        if (pitch_diff[9]) begin
            pitch_c = 8'd0;
        end else if (pitch_diff[8]) begin
            pitch_c = 8'hFF;
        end else begin
            pitch_c = pitch_diff[7:0];
        end
        roll_prod  = 18'(r_scale) * 18'(roll_c);
        pitch_prod = 18'(r_scale) * 18'(pitch_c);
        yaw_prod   = 18'(r_scale) * 18'(yaw_s);
        roll_map   = 12'(roll_prod[17:8]) + 12'(rcsfe_pkg::MAP_BASE);
        pitch_map  = 12'(pitch_prod[17:8]) + 12'(rcsfe_pkg::MAP_BASE);
        yaw_map    = 12'(yaw_prod[17:8]) + 12'(rcsfe_pkg::MAP_BASE);
        if (yaw_map < 12'(rcsfe_pkg::YAW_MIN)) begin
            yaw_clamp = 12'(rcsfe_pkg::YAW_MIN);
        end else if (yaw_map > 12'(rcsfe_pkg::YAW_MAX)) begin
            yaw_clamp = 12'(rcsfe_pkg::YAW_MAX);
        end else begin
            yaw_clamp = yaw_map;
        end
        // floor(3.5 x) as (7 x) >> 1
        thr_map  = 11'((11'(thr_s) * 11'd7) >> 1) + 11'(rcsfe_pkg::THR_BASE);
        bat_prod = 17'(bat_s) * 17'(rcsfe_pkg::BAT_GAIN);
    end

    // trim step applied after the channel frame, within the limits
    always_comb begin
        n_roll_trim  = r_roll_trim;
        n_pitch_trim = r_pitch_trim;
        press        = 1'b0;
        case (btn)
            rcsfe_pkg::BTN_ROLL_UP: begin
                press = 1'b1;
                if (r_roll_trim < TRIM_LIM_S) n_roll_trim = r_roll_trim + TRIM_STEP_S;
            end
            rcsfe_pkg::BTN_ROLL_DOWN: begin
                press = 1'b1;
                if (r_roll_trim > -TRIM_LIM_S) n_roll_trim = r_roll_trim - TRIM_STEP_S;
            end
            rcsfe_pkg::BTN_PITCH_UP: begin
                press = 1'b1;
                if (r_pitch_trim < TRIM_LIM_S) n_pitch_trim = r_pitch_trim + TRIM_STEP_S;
            end
            rcsfe_pkg::BTN_PITCH_DOWN: begin
                press = 1'b1;
                if (r_pitch_trim > -TRIM_LIM_S) n_pitch_trim = r_pitch_trim - TRIM_STEP_S;
            end
            default: begin
                press = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_job.thr        = thr_map;
        o_job.yaw        = yaw_clamp;
        o_job.roll       = roll_map;
        o_job.pitch      = pitch_map;
        o_job.aux[0]     = i_data[55:40];
        o_job.aux[1]     = i_data[71:56];
        o_job.aux[2]     = i_data[87:72];
        o_job.aux[3]     = i_data[103:88];
        o_job.bat_low    = (bat_prod[16:8] <= 9'(rcsfe_pkg::BAT_LOW_LEVEL));
        o_job.thr_active = (thr_map > 11'(rcsfe_pkg::THR_ACTIVE));
        o_job.trim_en    = r_pend || press;
        o_job.roll_trim  = {{3{n_roll_trim[12]}}, n_roll_trim};
        o_job.pitch_trim = {{3{n_pitch_trim[12]}}, n_pitch_trim};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch_off  <= 8'd0;
            r_roll_off   <= 8'd0;
            r_scale      <= rcsfe_pkg::SCALE_RESET;
            r_roll_trim  <= '0;
            r_pitch_trim <= '0;
            r_pend       <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    rcsfe_pkg::CFG_PITCH_OFFSET: r_pitch_off <= i_cfg_data[7:0];
                    rcsfe_pkg::CFG_ROLL_OFFSET:  r_roll_off  <= i_cfg_data[7:0];
                    rcsfe_pkg::CFG_SCALE:        r_scale     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_roll_trim  <= n_roll_trim;
                r_pitch_trim <= n_pitch_trim;
                // any pending trim frame goes out with this item
                r_pend       <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/core/rcsfe_queue.sv -----
// short job queue between front end and serializer
`timescale 1ns / 1ps

module rcsfe_queue #(
    parameter int DEPTH = rcsfe_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_push_ready,
    input  rcsfe_pkg::t_job    i_job,
    output logic               o_nonempty,
    input  logic               i_pop,
    output rcsfe_pkg::t_job    o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rcsfe_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_nonempty   = (r_count != '0);
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_nonempty;
    assign o_job        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/rcsfe_back.sv -----
// serializer: turns a job into frame bytes with running checksum
`timescale 1ns / 1ps

module rcsfe_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_nonempty,
    input  rcsfe_pkg::t_job    i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_data,
    output logic               o_last,
    output logic [2:0]         o_user
);

    logic [4:0]   r_pos;
    logic [7:0]   r_sum;
    logic         r_valid;
    logic [7:0]   r_data;
    logic         r_last;
    logic [2:0]   r_user;

    logic [4:0]   n_pos;
    logic [7:0]   n_sum;
    logic [7:0]   byte_sel;
    logic         is_sum;
    logic         is_last;
    logic         emit;
    logic [127:0] words;
    logic [31:0]  trims;
    logic [4:0]   word_off;
    logic [4:0]   trim_off;

    assign emit = i_nonempty && (!r_valid || i_ready);

    always_comb begin
        words = {i_job.aux[3], i_job.aux[2], i_job.aux[1], i_job.aux[0],
                 4'd0, i_job.pitch, 4'd0, i_job.roll, 4'd0, i_job.yaw, 5'd0, i_job.thr};
        trims    = {i_job.pitch_trim, i_job.roll_trim};
        word_off = r_pos - rcsfe_pkg::POS_CH_WORDS;
        trim_off = r_pos - rcsfe_pkg::POS_TRIM_WORDS;
        is_sum   = (r_pos == rcsfe_pkg::POS_CH_SUM) || (r_pos == rcsfe_pkg::POS_TRIM_SUM);
        is_last  = i_job.trim_en ? (r_pos == rcsfe_pkg::POS_TRIM_SUM)
                                 : (r_pos == rcsfe_pkg::POS_CH_SUM);
        case (r_pos)
            5'd0, 5'd21: byte_sel = rcsfe_pkg::SYNC_0;
            5'd1, 5'd22: byte_sel = rcsfe_pkg::SYNC_1;
            5'd2:        byte_sel = rcsfe_pkg::CH_ID;
            5'd3:        byte_sel = rcsfe_pkg::CH_LEN;
            5'd23:       byte_sel = rcsfe_pkg::TRIM_ID;
            5'd24:       byte_sel = rcsfe_pkg::TRIM_LEN;
            5'd20, 5'd29: byte_sel = r_sum;
            5'd25, 5'd26, 5'd27, 5'd28: byte_sel = trims[{trim_off[1:0], 3'b000} +: 8];
            default:     byte_sel = words[{word_off[3:0], 3'b000} +: 8];
        endcase
        // checksum restarts after each frame
        n_sum = is_sum ? 8'd0 : r_sum + byte_sel;
        n_pos = is_last ? 5'd0 : r_pos + 5'd1;
    end

    assign o_pop   = emit && is_last;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;
    assign o_user  = r_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 5'd0;
            r_sum   <= 8'd0;
            r_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_pos   <= n_pos;
                r_sum   <= n_sum;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_data <= byte_sel;
            r_last <= is_last;
            r_user <= {i_job.thr_active, i_job.bat_low, is_sum};
        end
    end

endmodule

// ----- rtl/core/rc_stick_frame_encoder.sv -----
// top level of the rc stick frame encoder
`timescale 1ns / 1ps

// Each accepted sample set becomes a 21-byte channel frame (AA AF 03 10, eight
// little-endian words, byte-sum checksum), followed by a 9-byte trim frame
// (AA AF 16 04, roll and pitch trim, checksum) after reset or after any trim
// press. The front end takes a sample set whenever the job queue has room;
// the serializer sends one byte per cycle while the output is not stalled,
// so an item is 21 bytes long, or 30 with a trim frame, and sustained rate
// is set by that serializer. The job queue holds up to QUEUE_DEPTH jobs, the
// one being sent included, so QUEUE_DEPTH - 1 jobs can wait behind it.
// Configuration writes are always ready and must be done while idle.
module rc_stick_frame_encoder #(
    parameter int QUEUE_DEPTH = rcsfe_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [9:0]   i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // throttle_sample, yaw_sample, roll_sample, pitch_sample, battery_sample,
    // aux_one, aux_two, aux_three, aux_four, trim_button, zero fill
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tx_byte
    output logic [7:0]   m_axis_tdata,
    output logic         m_axis_tlast,
    // frame_end, battery_low, throttle_active
    output logic [2:0]   m_axis_tuser
);

    rcsfe_pkg::t_job front_job;
    rcsfe_pkg::t_job head_job;
    logic            push;
    logic            push_ready;
    logic            nonempty;
    logic            pop;

    assign o_cfg_ready = 1'b1;

    rcsfe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data       (s_axis_tdata),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_job        (front_job)
    );

    rcsfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_job        (front_job),
        .o_nonempty   (nonempty),
        .i_pop        (pop),
        .o_job        (head_job)
    );

    rcsfe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (nonempty),
        .i_job      (head_job),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata),
        .o_last     (m_axis_tlast),
        .o_user     (m_axis_tuser)
    );

endmodule

// ----- rtl/core/rcsfe_checker.sv -----
// port-level checks for the rc stick frame encoder, bound to the top level
`timescale 1ns / 1ps

module rcsfe_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [7:0]   m_axis_tdata,
    input  logic         m_axis_tlast,
    input  logic [2:0]   m_axis_tuser
);

    // the last byte of an item always closes a frame
    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
        else $error("tlast without frame end");

    // output is empty right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // flags stay the same from one byte of an item to the next
    a_flags_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid
        |-> m_axis_tuser[2:1] == $past(m_axis_tuser[2:1]))
        else $error("flags changed within an item");

    // stalled output transfer holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

endmodule

bind rc_stick_frame_encoder rcsfe_checker u_rcsfe_checker (.*);

// ----- tb/sv/tb.sv -----
// self-checking testbench for the rc stick frame encoder
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [7:0]  throttle_sample;
        logic [7:0]  yaw_sample;
        logic [7:0]  roll_sample;
        logic [7:0]  pitch_sample;
        logic [7:0]  battery_sample;
        logic [15:0] aux_one;
        logic [15:0] aux_two;
        logic [15:0] aux_three;
        logic [15:0] aux_four;
        logic [2:0]  trim_button;
    } t_stick_set;

    typedef struct {
        logic [7:0] tx_byte;
        logic       frame_end;
        logic       last;
        logic       battery_low;
        logic       throttle_active;
    } t_frame_byte;

    typedef logic [7:0] t_frame_buf [20];

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [9:0]   i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // throttle_sample, yaw_sample, roll_sample, pitch_sample, battery_sample,
    // aux_one, aux_two, aux_three, aux_four, trim_button, zero fill
    logic [111:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // tx_byte
    logic [7:0]   m_axis_tdata;
    logic         m_axis_tlast;
    // frame_end, battery_low, throttle_active
    logic [2:0]   m_axis_tuser;

    rc_stick_frame_encoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // encoder copy: configuration and trim state
    logic signed [7:0] pitch_ofs = '0;
    logic signed [7:0] roll_ofs = '0;
    logic [9:0]        gain_q8 = rcsfe_pkg::SCALE_RESET;
    int                roll_trim = 0;
    int                pitch_trim = 0;
    logic              trim_pending = 1'b1;

    t_frame_byte frame_bytes_q[$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          cycle_count = 0;

    function automatic int clamp_stick(input int v);
        if (v < 0) return 0;
        if (v > 255) return 255;
        return v;
    endfunction

    function automatic int scale_stick(input int x);
        return ((int'(gain_q8) * x) >> 8) + rcsfe_pkg::MAP_BASE;
    endfunction

    task automatic push_frame(input t_frame_buf fb, input int len, input logic bl,
                              input logic ta, input logic ends_call);
        logic [7:0]  sum;
        t_frame_byte b;
        sum = '0;
        b.battery_low = bl;
        b.throttle_active = ta;
        b.frame_end = 1'b0;
        b.last = 1'b0;
        for (int i = 0; i < len; i++) begin
            sum += fb[i];
            b.tx_byte = fb[i];
            frame_bytes_q.push_back(b);
        end
        b.tx_byte = sum;
        b.frame_end = 1'b1;
        b.last = ends_call;
        frame_bytes_q.push_back(b);
    endtask

    task automatic encode_frames(input t_stick_set s);
        int          pitch_w, roll_w, yaw_w, thr_w;
        logic        bl, ta;
        t_frame_buf  fb;
        logic [15:0] words [8];
        logic [15:0] rt, pt;
        pitch_w = scale_stick(clamp_stick(int'(s.pitch_sample) - int'(pitch_ofs)));
        roll_w = scale_stick(clamp_stick(int'(s.roll_sample) - int'(roll_ofs)));
        yaw_w = scale_stick(int'(s.yaw_sample));
        if (yaw_w < rcsfe_pkg::YAW_MIN) yaw_w = rcsfe_pkg::YAW_MIN;
        if (yaw_w > rcsfe_pkg::YAW_MAX) yaw_w = rcsfe_pkg::YAW_MAX;
        thr_w = ((7 * int'(s.throttle_sample)) >> 1) + rcsfe_pkg::THR_BASE;
        bl = (((rcsfe_pkg::BAT_GAIN * int'(s.battery_sample)) >> 8)
              <= rcsfe_pkg::BAT_LOW_LEVEL);
        ta = (thr_w > rcsfe_pkg::THR_ACTIVE);
        words[0] = thr_w[15:0];
        words[1] = yaw_w[15:0];
        words[2] = roll_w[15:0];
        words[3] = pitch_w[15:0];
        words[4] = s.aux_one;
        words[5] = s.aux_two;
        words[6] = s.aux_three;
        words[7] = s.aux_four;
        fb[0] = rcsfe_pkg::SYNC_0;
        fb[1] = rcsfe_pkg::SYNC_1;
        fb[2] = rcsfe_pkg::CH_ID;
        fb[3] = rcsfe_pkg::CH_LEN;
        for (int i = 0; i < 8; i++) begin
            fb[4 + 2 * i] = words[i][7:0];
            fb[5 + 2 * i] = words[i][15:8];
        end
        // trim press at the limit still asks for a trim frame
        case (s.trim_button)
            rcsfe_pkg::BTN_ROLL_UP: begin
                if (roll_trim < rcsfe_pkg::TRIM_LIMIT) roll_trim += rcsfe_pkg::TRIM_STEP;
                trim_pending = 1'b1;
            end
            rcsfe_pkg::BTN_ROLL_DOWN: begin
                if (roll_trim > -rcsfe_pkg::TRIM_LIMIT) roll_trim -= rcsfe_pkg::TRIM_STEP;
                trim_pending = 1'b1;
            end
            rcsfe_pkg::BTN_PITCH_UP: begin
                if (pitch_trim < rcsfe_pkg::TRIM_LIMIT) pitch_trim += rcsfe_pkg::TRIM_STEP;
                trim_pending = 1'b1;
            end
            rcsfe_pkg::BTN_PITCH_DOWN: begin
                if (pitch_trim > -rcsfe_pkg::TRIM_LIMIT) pitch_trim -= rcsfe_pkg::TRIM_STEP;
                trim_pending = 1'b1;
            end
            default: ;
        endcase
        push_frame(fb, 20, bl, ta, !trim_pending);
        if (trim_pending) begin
            rt = roll_trim[15:0];
            pt = pitch_trim[15:0];
            fb[0] = rcsfe_pkg::SYNC_0;
            fb[1] = rcsfe_pkg::SYNC_1;
            fb[2] = rcsfe_pkg::TRIM_ID;
            fb[3] = rcsfe_pkg::TRIM_LEN;
            fb[4] = rt[7:0];
            fb[5] = rt[15:8];
            fb[6] = pt[7:0];
            fb[7] = pt[15:8];
            push_frame(fb, 8, bl, ta, 1'b1);
            trim_pending = 1'b0;
        end
    endtask

    // valid is only lowered for a gap, so back-to-back transfers keep it high
    task automatic send_item(input t_stick_set s);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, s.trim_button, s.aux_four, s.aux_three, s.aux_two,
                         s.aux_one, s.battery_sample, s.pitch_sample, s.roll_sample,
                         s.yaw_sample, s.throttle_sample};
        do @(posedge i_clk); while (!s_axis_tready);
        encode_frames(s);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (frame_bytes_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_config(input logic signed [7:0] p_ofs, input logic signed [7:0] r_ofs,
                              input logic [9:0] gain);
        write_reg(rcsfe_pkg::CFG_PITCH_OFFSET, {2'b00, p_ofs});
        write_reg(rcsfe_pkg::CFG_ROLL_OFFSET, {2'b00, r_ofs});
        write_reg(rcsfe_pkg::CFG_SCALE, gain);
        i_cfg_valid <= 1'b0;
        pitch_ofs = p_ofs;
        roll_ofs = r_ofs;
        gain_q8 = gain;
        @(posedge i_clk);
    endtask

    task automatic set_idle_mode(input int snd_pct, input int rcv_pct);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
    endtask

    function automatic t_stick_set make_stick(input logic [7:0] thr, input logic [7:0] yaw,
                                              input logic [7:0] roll, input logic [7:0] pitch,
                                              input logic [7:0] bat, input logic [15:0] aux,
                                              input logic [2:0] btn);
        t_stick_set s;
        s.throttle_sample = thr;
        s.yaw_sample = yaw;
        s.roll_sample = roll;
        s.pitch_sample = pitch;
        s.battery_sample = bat;
        s.aux_one = aux;
        s.aux_two = ~aux;
        s.aux_three = {aux[7:0], aux[15:8]};
        s.aux_four = aux ^ 16'h0F0F;
        s.trim_button = btn;
        return s;
    endfunction

    // readings pinned to the rails now and then
    function automatic logic [7:0] rand_reading();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic t_stick_set rand_stick();
        t_stick_set s;
        s.throttle_sample = rand_reading();
        s.yaw_sample = rand_reading();
        s.roll_sample = rand_reading();
        s.pitch_sample = rand_reading();
        s.battery_sample = rand_reading();
        s.aux_one = 16'($urandom_range(65535));
        s.aux_two = 16'($urandom_range(65535));
        s.aux_three = 16'($urandom_range(65535));
        s.aux_four = 16'($urandom_range(65535));
        s.trim_button = 3'($urandom_range(7));
        return s;
    endfunction

    task automatic test_sample_extremes();
        send_item(make_stick(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 3'd0));
        send_item(make_stick(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF, 3'd0));
        // throttle and battery flags on either side of their thresholds
        send_item(make_stick(8'd57, 8'd22, 8'd128, 8'd128, 8'd160, 16'h5555, 3'd0));
        send_item(make_stick(8'd58, 8'd182, 8'd127, 8'd129, 8'd161, 16'hAAAA, 3'd0));
        // yaw just inside both clamps
        send_item(make_stick(8'd100, 8'd23, 8'd1, 8'd254, 8'd200, 16'h8001, 3'd0));
        send_item(make_stick(8'd200, 8'd180, 8'd254, 8'd1, 8'd100, 16'h7FFE, 3'd0));
    endtask

    task automatic test_trim_limits();
        // roll climbs into its upper limit, pitch into its lower one
        repeat (6) send_item(make_stick(8'd80, 8'd128, 8'd128, 8'd128, 8'd180,
                                        16'h1234, rcsfe_pkg::BTN_ROLL_UP));
        repeat (6) send_item(make_stick(8'd90, 8'd128, 8'd128, 8'd128, 8'd150,
                                        16'h4321, rcsfe_pkg::BTN_PITCH_DOWN));
        // undefined codes act as no press
        for (int c = 5; c <= 7; c++)
            send_item(make_stick(8'd30, 8'd60, 8'd90, 8'd120, 8'd170, 16'hC3C3, 3'(c)));
        send_item(make_stick(8'd140, 8'd70, 8'd200, 8'd50, 8'd255, 16'h00FF,
                             rcsfe_pkg::BTN_ROLL_DOWN));
        send_item(make_stick(8'd10, 8'd240, 8'd60, 8'd190, 8'd0, 16'hFF00,
                             rcsfe_pkg::BTN_PITCH_UP));
    endtask

    task automatic test_register_settings();
        wait_idle();
        set_config(-8'sd128, 8'sd127, 10'd0);
        repeat (12) send_item(rand_stick());
        wait_idle();
        set_config(8'sd127, -8'sd128, 10'd1023);
        repeat (12) send_item(rand_stick());
        wait_idle();
        set_config(-8'sd20, 8'sd35, 10'd512);
        repeat (12) send_item(rand_stick());
        wait_idle();
        set_config(8'sd0, 8'sd0, rcsfe_pkg::SCALE_RESET);
        repeat (12) send_item(rand_stick());
    endtask

    task automatic test_random_traffic(input int items);
        logic [9:0] gain;
        wait_idle();
        case ($urandom_range(3))
            0: gain = 10'd0;
            1: gain = 10'd1023;
            default: gain = 10'($urandom_range(1023));
        endcase
        set_config(8'($urandom_range(255)), 8'($urandom_range(255)), gain);
        repeat (items) send_item(rand_stick());
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            error_count++;
            $error("%s expected %0h got %0h", name, exp_v, act_v);
        end
    endtask

    // output checker and receiver stalls
    always @(posedge i_clk) begin : check_output
        t_frame_byte exp_b;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (frame_bytes_q.size() == 0) begin
                error_count++;
                $error("unexpected transfer, tx_byte %0h", m_axis_tdata);
            end else begin
                exp_b = frame_bytes_q.pop_front();
                check_field("tx_byte", exp_b.tx_byte, m_axis_tdata);
                check_field("frame_end", 8'(exp_b.frame_end), 8'(m_axis_tuser[0]));
                check_field("last", 8'(exp_b.last), 8'(m_axis_tlast));
                check_field("battery_low", 8'(exp_b.battery_low), 8'(m_axis_tuser[1]));
                check_field("throttle_active", 8'(exp_b.throttle_active),
                            8'(m_axis_tuser[2]));
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL rc_stick_frame_encoder");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_idle_mode(38, 76);
        test_sample_extremes();
        test_trim_limits();
        test_register_settings();
        test_random_traffic(150);
        set_idle_mode(76, 38);
        test_random_traffic(150);
        set_idle_mode(0, 0);
        test_random_traffic(150);
        wait_idle();
        if (error_count == 0 && frame_bytes_q.size() == 0) begin
            $display("PASS rc_stick_frame_encoder");
        end else begin
            $display("FAIL rc_stick_frame_encoder");
        end
        $finish;
    end

endmodule
